@@ design/slf_pkg.sv @@
package slf_pkg;

  localparam logic [15:0] ONE_Q15 = 16'h8000;
  localparam logic [15:0] LN2_Q16 = 16'd45426;

  // Register map, one word apart
  typedef enum logic [2:0] {
    REG_ATTACK       = 3'd0,
    REG_ENV_DECAY    = 3'd1,
    REG_PEAK_DECAY   = 3'd2,
    REG_THR_ALPHA    = 3'd3,
    REG_SMOOTH_ALPHA = 3'd4,
    REG_WARP_GAIN    = 3'd5,
    REG_WARP_SCALE   = 3'd6,
    REG_BAND_COUNT   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] attack_coef;
    logic [15:0] env_decay;
    logic [15:0] peak_decay;
    logic [15:0] thresh_alpha;
    logic [15:0] smooth_alpha;
    logic [15:0] warp_gain;
    logic [15:0] warp_scale;
    logic [5:0]  band_count;
  } cfg_t;

  // ln(1 + i/16) in Q16, i = 0..16
  function automatic logic [15:0] ln_tab(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0:  v = 16'd0;
      5'd1:  v = 16'd3973;
      5'd2:  v = 16'd7719;
      5'd3:  v = 16'd11262;
      5'd4:  v = 16'd14624;
      5'd5:  v = 16'd17821;
      5'd6:  v = 16'd20870;
      5'd7:  v = 16'd23783;
      5'd8:  v = 16'd26573;
      5'd9:  v = 16'd29248;
      5'd10: v = 16'd31818;
      5'd11: v = 16'd34292;
      5'd12: v = 16'd36675;
      5'd13: v = 16'd38975;
      5'd14: v = 16'd41196;
      5'd15: v = 16'd43345;
      5'd16: v = 16'd45426;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

@@ design/slf_in_if.sv @@
interface slf_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [15:0] magnitude;
  logic       frame_last;
  logic [5:0] edge_index;
  logic [9:0] edge_bin;

  modport source(output valid, mode, magnitude, frame_last, edge_index, edge_bin,
                 input ready);
  modport sink(input valid, mode, magnitude, frame_last, edge_index, edge_bin,
               output ready);
endinterface

@@ design/slf_out_if.sv @@
interface slf_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] band_index;
  logic [15:0] level;
  logic       last_band;

  modport source(output valid, band_index, level, last_band, input ready);
  modport sink(input valid, band_index, level, last_band, output ready);
endinterface

@@ design/spectrum_band_level_follower.sv @@
// Channel   Dir  Handshake      Payload
// bin_i     in   valid/ready    mode, magnitude, frame_last, edge_index, edge_bin
// level_o   out  valid/ready    band_index, level, last_band
// apb       in   psel/penable   paddr, pwdata -> prdata, pready tied high
//
// An edge write is taken while idle; a bin is read, added, then checked against
// each band it closes in turn, waiting to push while the queue is full.
// Each closed band runs the back end's state chain, which waits on the shared
// one-bit-a-cycle divider (NW = 31 at default widths).
// A 4-entry queue between front and back lets bins flow while bands run.
// Reset clears per-band state at once through valid bits; no clearing pass.
module spectrum_band_level_follower #(
  parameter int unsigned MAX_BANDS = 32,
  parameter int unsigned MAX_BINS  = 512,
  parameter int unsigned MAG_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slf_in_if.sink      bin_i,
  slf_out_if.source   level_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import slf_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_BANDS + 1);
  localparam int unsigned BW    = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int unsigned EW    = $clog2(MAX_BINS + 1);
  localparam int unsigned SUM_W = MAG_BITS + EW;
  localparam int unsigned CMD_W = 1 + BW + EW + SUM_W;
  localparam int unsigned QDEPTH = 4;

  cfg_t             cfg_q;
  logic             cfg_we;
  logic [6:0]       bc7;
  logic [CW-1:0]    bc_w;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  logic [CMD_W-1:0] push_data, pop_data;

  // Register writes on the access phase
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_coef  <= 16'd16384;
      cfg_q.env_decay    <= 16'd31130;
      cfg_q.peak_decay   <= 16'd32440;
      cfg_q.thresh_alpha <= 16'd29491;
      cfg_q.smooth_alpha <= 16'd16384;
      cfg_q.warp_gain    <= 16'd2560;
      cfg_q.warp_scale   <= 16'd1708;
      cfg_q.band_count   <= 6'd32;
    end else if (cfg_we) begin
      case (reg_idx_e'(paddr[4:2]))
        REG_ATTACK:       cfg_q.attack_coef  <= pwdata[15:0];
        REG_ENV_DECAY:    cfg_q.env_decay    <= pwdata[15:0];
        REG_PEAK_DECAY:   cfg_q.peak_decay   <= pwdata[15:0];
        REG_THR_ALPHA:    cfg_q.thresh_alpha <= pwdata[15:0];
        REG_SMOOTH_ALPHA: cfg_q.smooth_alpha <= pwdata[15:0];
        REG_WARP_GAIN:    cfg_q.warp_gain    <= pwdata[15:0];
        REG_WARP_SCALE:   cfg_q.warp_scale   <= pwdata[15:0];
        REG_BAND_COUNT:   cfg_q.band_count   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx_e'(paddr[4:2]))
      REG_ATTACK:       prdata = 32'(cfg_q.attack_coef);
      REG_ENV_DECAY:    prdata = 32'(cfg_q.env_decay);
      REG_PEAK_DECAY:   prdata = 32'(cfg_q.peak_decay);
      REG_THR_ALPHA:    prdata = 32'(cfg_q.thresh_alpha);
      REG_SMOOTH_ALPHA: prdata = 32'(cfg_q.smooth_alpha);
      REG_WARP_GAIN:    prdata = 32'(cfg_q.warp_gain);
      REG_WARP_SCALE:   prdata = 32'(cfg_q.warp_scale);
      REG_BAND_COUNT:   prdata = 32'(cfg_q.band_count);
      default:          prdata = '0;
    endcase
  end

  // Clamp band count to one .. MAX_BANDS
  assign bc7  = 7'(cfg_q.band_count);
  assign bc_w = (bc7 == 7'd0) ? CW'(1) :
                (bc7 > 7'(MAX_BANDS)) ? CW'(MAX_BANDS) : CW'(bc7);

  slf_front #(.MAX_BANDS(MAX_BANDS), .MAX_BINS(MAX_BINS), .MAG_BITS(MAG_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bin_i       (bin_i),
    .bc_i        (bc_w),
    .cmd_valid_o (push_valid),
    .cmd_ready_i (push_ready),
    .cmd_o       (push_data)
  );

  slf_queue #(.W(CMD_W), .DEPTH(QDEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  slf_back #(.MAX_BANDS(MAX_BANDS), .MAX_BINS(MAX_BINS), .MAG_BITS(MAG_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_data),
    .level_o     (level_o)
  );

  // Checks
  a_bc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bc_w >= CW'(1)) && (bc_w <= CW'(MAX_BANDS)))
    else $error("band count out of range");

  a_bc_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we && (paddr[4:2] == REG_BAND_COUNT)) |=> (cfg_q.band_count == $past(pwdata[5:0])))
    else $error("band count write lost");

  a_cmd_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid && push_ready) |-> ((CW+1)'(push_data[CMD_W-2 -: BW]) < (CW+1)'(bc_w)))
    else $error("closed band beyond band count");
endmodule

@@ design/slf_queue.sv @@
module slf_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] cnt_q;
  logic          push, pop;

  assign push_ready_o = cnt_q < NW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Hold entries
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end
endmodule

@@ design/slf_div.sv @@
module slf_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  localparam int unsigned CNW = $clog2(NW + 1);

  logic           busy_q, done_q;
  logic [CNW-1:0] cnt_q;
  logic [NW-1:0]  q_q;
  logic [DW-1:0]  r_q, d_q;
  logic [DW:0]    rs;
  logic           ge;

  // One quotient bit a cycle, restoring
  assign rs     = {r_q, q_q[NW-1]};
  assign ge     = rs >= {1'b0, d_q};
  assign done_o = done_q;
  assign quo_o  = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      r_q <= ge ? DW'(rs - {1'b0, d_q}) : rs[DW-1:0];
      q_q <= {q_q[NW-2:0], ge};
    end
  end
endmodule

@@ design/slf_front.sv @@
module slf_front #(
  parameter int unsigned MAX_BANDS = 32,
  parameter int unsigned MAX_BINS  = 512,
  parameter int unsigned MAG_BITS  = 16,
  localparam int unsigned CW    = $clog2(MAX_BANDS + 1),
  localparam int unsigned BW    = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1,
  localparam int unsigned EW    = $clog2(MAX_BINS + 1),
  localparam int unsigned SUM_W = MAG_BITS + EW,
  localparam int unsigned CMD_W = 1 + BW + EW + SUM_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  slf_in_if.sink           bin_i,
  input  logic [CW-1:0]    bc_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output logic [CMD_W-1:0] cmd_o
);
  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_RD   = 4'b0010,
    F_EVAL = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_e;

  fstate_e          state_q;
  logic [CW-1:0]    cur_q, cur_nx;
  logic [EW-1:0]    bin_q;
  logic [SUM_W-1:0] sum_q;
  logic [MAG_BITS-1:0] mag_q;
  logic             last_q, added_q;
  logic [EW-1:0]    edge_mem [MAX_BANDS + 1];
  logic [EW-1:0]    es_q, ee_q;

  logic             accept, edge_we;
  logic [CW-1:0]    edge_wa;
  logic [EW-1:0]    edge_wd;
  logic [23:0]      mag_ext;
  logic [12:0]      eb_ext, eb_c;
  logic             active, inband, close;
  logic [EW-1:0]    cnt;

  assign bin_i.ready = state_q == F_IDLE;
  assign accept      = bin_i.valid && bin_i.ready;
  assign mag_ext     = 24'(bin_i.magnitude);

  // Edge writes: drop entries past the table, clamp the bin
  assign eb_ext  = 13'(bin_i.edge_bin);
  assign eb_c    = (eb_ext > 13'(MAX_BINS)) ? 13'(MAX_BINS) : eb_ext;
  assign edge_we = accept && bin_i.mode && (7'(bin_i.edge_index) <= 7'(MAX_BANDS));
  assign edge_wa = CW'(bin_i.edge_index);
  assign edge_wd = EW'(eb_c);

  // Edge table, read at the open band's start and end
  assign cur_nx = (cur_q == CW'(MAX_BANDS)) ? cur_q : CW'(cur_q + 1'b1);

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    es_q <= edge_mem[cur_q];
    ee_q <= edge_mem[cur_nx];
  end

  // Classify the bin against the open band
  assign active = cur_q < bc_i;
  assign inband = (es_q <= bin_q) && (bin_q < ee_q);
  assign close  = active && (((EW+1)'(ee_q) <= (EW+1)'(bin_q) + 1'b1) || last_q);
  assign cnt    = (ee_q > es_q) ? EW'(ee_q - es_q) : EW'(1);

  assign cmd_valid_o = state_q == F_PUSH;
  assign cmd_o = {(CW'(cur_q + 1'b1) == bc_i), BW'(cur_q), cnt, sum_q};

  // Hold the bin payload
  always_ff @(posedge clk_i) begin
    if (accept && !bin_i.mode) begin
      mag_q  <= mag_ext[MAG_BITS-1:0];
      last_q <= bin_i.frame_last;
    end
  end

  // Sequence one bin: add, then close bands one by one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cur_q   <= '0;
      bin_q   <= '0;
      sum_q   <= '0;
      added_q <= 1'b0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (accept && !bin_i.mode) begin
            state_q <= F_RD;
            added_q <= 1'b0;
          end
        end
        F_RD: state_q <= F_EVAL;
        F_EVAL: begin
          if (!added_q) begin
            added_q <= 1'b1;
            if (active && inband) sum_q <= sum_q + SUM_W'(mag_q);
          end else if (close) begin
            state_q <= F_PUSH;
          end else begin
            if (last_q) begin
              cur_q <= '0;
              sum_q <= '0;
              bin_q <= '0;
            end else if (bin_q < EW'(MAX_BINS)) begin
              bin_q <= bin_q + 1'b1;
            end
            state_q <= F_IDLE;
          end
        end
        F_PUSH: begin
          if (cmd_ready_i) begin
            sum_q   <= '0;
            cur_q   <= CW'(cur_q + 1'b1);
            state_q <= F_RD;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end
endmodule

@@ design/slf_back.sv @@
module slf_back #(
  parameter int unsigned MAX_BANDS = 32,
  parameter int unsigned MAX_BINS  = 512,
  parameter int unsigned MAG_BITS  = 16,
  localparam int unsigned BW    = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1,
  localparam int unsigned EW    = $clog2(MAX_BINS + 1),
  localparam int unsigned SUM_W = MAG_BITS + EW,
  localparam int unsigned CMD_W = 1 + BW + EW + SUM_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  slf_pkg::cfg_t    cfg_i,
  input  logic             cmd_valid_i,
  output logic             cmd_ready_o,
  input  logic [CMD_W-1:0] cmd_i,
  slf_out_if.source        level_o
);
  import slf_pkg::*;

  localparam int unsigned NW0 = (SUM_W > MAG_BITS + 15) ? SUM_W : MAG_BITS + 15;
  localparam int unsigned NW  = (NW0 > 31) ? NW0 : 31;
  localparam int unsigned DW0 = (MAG_BITS > EW) ? MAG_BITS : EW;
  localparam int unsigned DW  = (DW0 > 16) ? DW0 : 16;
  localparam int unsigned SW  = 2 * MAG_BITS + 32;
  localparam logic [NW-1:0] MAG_MAX_N = NW'((64'd1 << MAG_BITS) - 64'd1);
  localparam logic [NW-1:0] ONE_N     = NW'(ONE_Q15);

  typedef enum logic [16:0] {
    B_IDLE = 17'h00001, B_RD   = 17'h00002, B_AVG  = 17'h00004,
    B_ENV1 = 17'h00008, B_ENV2 = 17'h00010, B_PK   = 17'h00020,
    B_NRMS = 17'h00040, B_NORM = 17'h00080, B_LOGM = 17'h00100,
    B_LOGN = 17'h00200, B_LN   = 17'h00400, B_WARP = 17'h00800,
    B_THR  = 17'h01000, B_ADJS = 17'h02000, B_ADJ  = 17'h04000,
    B_SM   = 17'h08000, B_OUT  = 17'h10000
  } bstate_e;

  function automatic logic [15:0] wgt(input logic [15:0] v);
    return (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

  // (p*w + x*(1-w) + half) >> 15, written as x + (p-x)*w
  function automatic logic [23:0] mix(input logic [23:0] p, input logic [23:0] x,
                                      input logic [15:0] w);
    logic signed [25:0] d;
    logic signed [43:0] t;
    d = $signed({2'b00, p}) - $signed({2'b00, x});
    t = $signed({5'b0, x, 15'b0}) + d * $signed({1'b0, w}) + 44'sd16384;
    return t[38:15];
  endfunction

  function automatic logic [23:0] dec(input logic [23:0] p, input logic [15:0] d);
    logic [39:0] t;
    t = 40'(p) * 40'(d) + 40'd16384;
    return t[38:15];
  endfunction

  bstate_e             state_q;
  logic [SUM_W-1:0]    sum_q;
  logic [EW-1:0]       cnt_q;
  logic [BW-1:0]       band_q;
  logic                last_q;
  logic [MAG_BITS-1:0] avg_q, rise_q, env_q, pk_q;
  logic [15:0]         norm_q, warp_q, thr_q, adj_q, sm_q;
  logic [31:0]         y_q;
  logic [3:0]          k_q;
  logic [19:0]         ln_q;
  logic [SW-1:0]       st_mem [MAX_BANDS];
  logic [SW-1:0]       rd_q;
  logic [MAX_BANDS-1:0] valid_q;
  logic                ov_q;
  logic [4:0]          ob_q;
  logic [15:0]         ol_q;
  logic                olast_q;

  logic                ent_v, st_we, div_start, div_done;
  logic [MAG_BITS-1:0] env_old, pk_old;
  logic [15:0]         thr_old, sm_old;
  logic [NW-1:0]       div_n, quo;
  logic [DW-1:0]       div_d;
  logic [23:0]         m_rise, m_fall, m_pk, m_thr, m_sm;
  logic [15:0]         t0, t1;
  logic [31:0]         interp;
  logic [19:0]         ln_w;
  logic [35:0]         wp;
  logic [31:0]         y_w;

  assign cmd_ready_o = state_q == B_IDLE;

  // Band state store; an entry not yet written reads as zero
  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[band_q] <= {env_q, pk_q, thr_q, m_sm[15:0]};
    rd_q <= st_mem[band_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= '0;
    else if (st_we) valid_q[band_q] <= 1'b1;
  end

  assign ent_v   = valid_q[band_q];
  assign env_old = ent_v ? rd_q[SW-1 -: MAG_BITS] : '0;
  assign pk_old  = ent_v ? rd_q[31+MAG_BITS -: MAG_BITS] : '0;
  assign thr_old = ent_v ? rd_q[31:16] : '0;
  assign sm_old  = ent_v ? rd_q[15:0] : '0;
  assign st_we   = state_q == B_SM;

  // Shared divider for average, ratio and threshold rescale
  always_comb begin
    div_start = 1'b0;
    div_n     = NW'(sum_q);
    div_d     = DW'(cnt_q);
    case (state_q)
      B_RD: div_start = 1'b1;
      B_NRMS: begin
        div_start = pk_q != '0;
        div_n     = NW'({env_q, 15'b0});
        div_d     = DW'(pk_q);
      end
      B_ADJS: begin
        div_start = warp_q > thr_q;
        div_n     = NW'({16'(warp_q - thr_q), 15'b0});
        div_d     = DW'(ONE_Q15 - thr_q);
      end
      default: div_start = 1'b0;
    endcase
  end

  slf_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  // Per-step arithmetic, one product each
  assign m_rise = mix(24'(env_old), 24'(avg_q), wgt(cfg_i.attack_coef));
  assign m_fall = dec(24'(env_old), wgt(cfg_i.env_decay));
  assign m_pk   = dec(24'(pk_old), wgt(cfg_i.peak_decay));
  assign m_thr  = mix(24'(thr_old), 24'(warp_q), wgt(cfg_i.thresh_alpha));
  assign m_sm   = mix(24'(sm_old), 24'(adj_q), wgt(cfg_i.smooth_alpha));
  assign y_w    = 32'(cfg_i.warp_gain) * 32'(norm_q) + 32'h0080_0000;
  assign t0     = ln_tab({1'b0, y_q[22:19]});
  assign t1     = ln_tab(5'({1'b0, y_q[22:19]} + 1'b1));
  assign interp = (32'(16'(t1 - t0)) * 32'(y_q[18:7]) + 32'd2048) >> 12;
  assign ln_w   = 20'(k_q) * 20'(LN2_Q16) + 20'(t0) + 20'(interp);
  assign wp     = 36'(ln_q) * 36'(cfg_i.warp_scale) + 36'd4096;

  // Hold the command and step through the band's chain
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: if (cmd_valid_i) {last_q, band_q, cnt_q, sum_q} <= cmd_i;
      B_AVG:  if (div_done) avg_q <= (quo > MAG_MAX_N) ? MAG_MAX_N[MAG_BITS-1:0]
                                                       : quo[MAG_BITS-1:0];
      B_ENV1: rise_q <= m_rise[MAG_BITS-1:0];
      B_ENV2: env_q <= (rise_q > m_fall[MAG_BITS-1:0]) ? rise_q : m_fall[MAG_BITS-1:0];
      B_PK:   pk_q <= (env_q > m_pk[MAG_BITS-1:0]) ? env_q : m_pk[MAG_BITS-1:0];
      B_NRMS: if (pk_q == '0) norm_q <= '0;
      B_NORM: if (div_done) norm_q <= (quo > ONE_N) ? ONE_Q15 : quo[15:0];
      B_LOGM: begin
        y_q <= y_w;
        k_q <= '0;
      end
      B_LOGN: if (y_q[31:24] != '0) begin
        y_q <= y_q >> 1;
        k_q <= k_q + 1'b1;
      end
      B_LN:   ln_q <= ln_w;
      B_WARP: warp_q <= (wp[35:13] > 23'(ONE_Q15)) ? ONE_Q15 : wp[28:13];
      B_THR:  thr_q <= m_thr[15:0];
      B_ADJS: if (!(warp_q > thr_q)) adj_q <= '0;
      B_ADJ:  if (div_done) adj_q <= (quo > ONE_N) ? ONE_Q15 : quo[15:0];
      B_SM:   sm_q <= m_sm[15:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      case (state_q)
        B_IDLE: if (cmd_valid_i) state_q <= B_RD;
        B_RD:   state_q <= B_AVG;
        B_AVG:  if (div_done) state_q <= B_ENV1;
        B_ENV1: state_q <= B_ENV2;
        B_ENV2: state_q <= B_PK;
        B_PK:   state_q <= B_NRMS;
        B_NRMS: state_q <= (pk_q == '0) ? B_LOGM : B_NORM;
        B_NORM: if (div_done) state_q <= B_LOGM;
        B_LOGM: state_q <= B_LOGN;
        B_LOGN: if (y_q[31:24] == '0) state_q <= B_LN;
        B_LN:   state_q <= B_WARP;
        B_WARP: state_q <= B_THR;
        B_THR:  state_q <= B_ADJS;
        B_ADJS: state_q <= (warp_q > thr_q) ? B_ADJ : B_SM;
        B_ADJ:  if (div_done) state_q <= B_SM;
        B_SM:   state_q <= B_OUT;
        B_OUT:  if (!ov_q || level_o.ready) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // Output register: a result waits here while the next band runs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (state_q == B_OUT && (!ov_q || level_o.ready)) begin
      ov_q <= 1'b1;
    end else if (level_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_OUT && (!ov_q || level_o.ready)) begin
      ob_q    <= 5'(band_q);
      ol_q    <= sm_q;
      olast_q <= last_q;
    end
  end

  assign level_o.valid      = ov_q;
  assign level_o.band_index = ob_q;
  assign level_o.level      = ol_q;
  assign level_o.last_band  = olast_q;
endmodule

@@ verif/slf_checker.sv @@
`timescale 1ns / 1ps

module slf_checker
  import slf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  slf_in_if           bin_mon,
  slf_out_if          lvl_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned items_seen,
  output int unsigned levels_seen
);

  typedef struct packed {
    logic [4:0]  band;
    logic [15:0] level;
    logic        last;
  } band_level_t;

  localparam int unsigned BANDS = 32;
  localparam int unsigned BINS  = 512;

  // ln(1 + i/16), Q16
  localparam int unsigned LN_STEP [17] = '{
    0, 3973, 7719, 11262, 14624, 17821, 20870, 23783, 26573,
    29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426
  };

  band_level_t expected_levels[$];

  int unsigned regs [8];
  int unsigned edges [BANDS+1];
  int unsigned envelope [BANDS];
  int unsigned peak_hold [BANDS];
  int unsigned thresh [BANDS];
  int unsigned smoothed [BANDS];
  longint unsigned band_sum;
  int unsigned bin_count;
  int unsigned cursor;

  assign pending = expected_levels.size();

  function automatic int unsigned clip_weight(int unsigned v);
    return (v > 32768) ? 32768 : v;
  endfunction

  function automatic int unsigned blend(int unsigned prev, int unsigned x, int unsigned w);
    longint unsigned t;
    t = longint'(prev) * w + longint'(x) * (32768 - w) + 16384;
    return int'(t >> 15);
  endfunction

  function automatic int unsigned shrink(int unsigned prev, int unsigned d);
    return int'((longint'(prev) * d + 16384) >> 15);
  endfunction

  function automatic int unsigned log_q16(int unsigned gain, int unsigned norm);
    longint unsigned y;
    int unsigned msb, frac, seg, lo;
    y = longint'(gain) * norm + (64'd1 << 23);
    msb = 23;
    while (msb < 40 && (y >> (msb + 1)) != 0) msb++;
    frac = int'(y >> (msb - 16)) - 65536;
    seg = (frac >> 12) & 15;
    lo = frac & 4095;
    return (msb - 23) * LN2_Q16 + LN_STEP[seg] +
           (((LN_STEP[seg+1] - LN_STEP[seg]) * lo + 2048) >> 12);
  endfunction

  // Work out one band's level and queue it
  function automatic void predict_band_level(int unsigned b, int unsigned bc);
    int unsigned lo_edge, hi_edge, avg, env, pk, norm, warped, thr, adj, rise, fall;
    longint unsigned cnt, q, lg;
    band_level_t r;
    lo_edge = edges[b];
    hi_edge = edges[b+1];
    cnt = (hi_edge > lo_edge) ? hi_edge - lo_edge : 1;
    q = band_sum / cnt;
    band_sum = 0;
    avg = (q > 65535) ? 65535 : int'(q);
    rise = blend(envelope[b], avg, clip_weight(regs[REG_ATTACK]));
    fall = shrink(envelope[b], clip_weight(regs[REG_ENV_DECAY]));
    env = (rise > fall) ? rise : fall;
    envelope[b] = env;
    pk = shrink(peak_hold[b], clip_weight(regs[REG_PEAK_DECAY]));
    if (env > pk) pk = env;
    peak_hold[b] = pk;
    norm = (pk != 0) ? int'((longint'(env) << 15) / pk) : 0;
    if (norm > 32768) norm = 32768;
    lg = log_q16(regs[REG_WARP_GAIN], norm);
    lg = (lg * regs[REG_WARP_SCALE] + 4096) >> 13;
    warped = (lg > 32768) ? 32768 : int'(lg);
    thr = blend(thresh[b], warped, clip_weight(regs[REG_THR_ALPHA]));
    thresh[b] = thr;
    adj = (warped <= thr) ? 0 : int'((longint'(warped - thr) << 15) / (32768 - thr));
    if (adj > 32768) adj = 32768;
    smoothed[b] = blend(smoothed[b], adj, clip_weight(regs[REG_SMOOTH_ALPHA]));
    r.band = b[4:0];
    r.level = smoothed[b][15:0];
    r.last = (b + 1 == bc);
    expected_levels.push_back(r);
  endfunction

  // Advance the band walk by one bin
  function automatic void take_bin(int unsigned mag, bit frame_end);
    int unsigned bc;
    bc = regs[REG_BAND_COUNT];
    if (bc < 1) bc = 1;
    if (bc > BANDS) bc = BANDS;
    if (cursor < bc && edges[cursor] <= bin_count && bin_count < edges[cursor+1])
      band_sum += mag;
    while (cursor < bc && edges[cursor+1] <= bin_count + 1) begin
      predict_band_level(cursor, bc);
      cursor++;
    end
    if (frame_end) begin
      while (cursor < bc) begin
        predict_band_level(cursor, bc);
        cursor++;
      end
      cursor = 0;
      band_sum = 0;
      bin_count = 0;
    end else if (bin_count < BINS) begin
      bin_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    band_level_t exp_r;
    if (!rst_ni) begin
      regs = '{16384, 31130, 32440, 29491, 16384, 2560, 1708, 32};
      foreach (edges[i]) edges[i] = 0;
      foreach (envelope[i]) begin
        envelope[i] = 0;
        peak_hold[i] = 0;
        thresh[i] = 0;
        smoothed[i] = 0;
      end
      band_sum = 0;
      bin_count = 0;
      cursor = 0;
      expected_levels.delete();
      fail_count <= 0;
      items_seen <= 0;
      levels_seen <= 0;
    end else begin
      // Register writes
      if (psel && penable && pwrite && paddr[4:2] <= REG_BAND_COUNT)
        regs[paddr[4:2]] = (paddr[4:2] == REG_BAND_COUNT) ? pwdata[5:0] : pwdata[15:0];
      // Input items
      if (bin_mon.valid && bin_mon.ready) begin
        items_seen <= items_seen + 1;
        if (bin_mon.mode) begin
          if (bin_mon.edge_index <= BANDS)
            edges[bin_mon.edge_index] = (bin_mon.edge_bin > BINS) ? BINS : bin_mon.edge_bin;
        end else begin
          take_bin(bin_mon.magnitude, bin_mon.frame_last);
        end
      end
      // Results
      if (lvl_mon.valid && lvl_mon.ready) begin
        levels_seen <= levels_seen + 1;
        if (expected_levels.size() == 0) begin
          $error("band level with none expected: band %0d level %0d",
                 lvl_mon.band_index, lvl_mon.level);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_levels.pop_front();
          if (lvl_mon.band_index !== exp_r.band || lvl_mon.level !== exp_r.level ||
              lvl_mon.last_band !== exp_r.last) begin
            fail_count <= fail_count + 1;
            if (lvl_mon.band_index !== exp_r.band)
              $error("band_index: expected %0d actual %0d", exp_r.band, lvl_mon.band_index);
            if (lvl_mon.level !== exp_r.level)
              $error("level: expected %0d actual %0d", exp_r.level, lvl_mon.level);
            if (lvl_mon.last_band !== exp_r.last)
              $error("last_band: expected %0d actual %0d", exp_r.last, lvl_mon.last_band);
          end
        end
      end
    end
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import slf_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 20000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        rx_ready = 1'b0;

  slf_in_if  bin_if ();
  slf_out_if lvl_if ();

  assign lvl_if.ready = rx_ready;

  int unsigned fail_count, pending, items_seen, levels_seen;
  int unsigned edge_shadow [33];
  int unsigned burst_left = 0;
  int unsigned random_bins = 0;
  int unsigned settings_run = 0;
  bit          no_gaps = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  logic [7:0]  pat_cnt = '0;
  int unsigned quiet = 0;

  spectrum_band_level_follower u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .bin_i   (bin_if),
    .level_o (lvl_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  slf_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bin_mon     (bin_if),
    .lvl_mon     (lvl_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .items_seen  (items_seen),
    .levels_seen (levels_seen)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: one long hold on request, otherwise a rolling stall pattern
  always @(posedge clk_i) begin
    pat_cnt <= pat_cnt + 8'd1;
    if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      rx_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rx_ready <= 1'b0;
    end else begin
      case (pat_cnt[7:6])
        2'd0: rx_ready <= 1'b1;
        2'd1: rx_ready <= 1'($urandom_range(0, 1));
        2'd2: rx_ready <= ($urandom_range(0, 3) == 0);
        default: rx_ready <= pat_cnt[2];
      endcase
    end
  end

  // Watchdog on cycles with no traffic
  always @(posedge clk_i) begin
    if ((bin_if.valid && bin_if.ready) || (lvl_if.valid && lvl_if.ready) || psel)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e r, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_all(int unsigned a, int unsigned ed, int unsigned pd, int unsigned ta,
                           int unsigned sa, int unsigned g, int unsigned s, int unsigned bc);
    write_reg(REG_ATTACK, a);
    write_reg(REG_ENV_DECAY, ed);
    write_reg(REG_PEAK_DECAY, pd);
    write_reg(REG_THR_ALPHA, ta);
    write_reg(REG_SMOOTH_ALPHA, sa);
    write_reg(REG_WARP_GAIN, g);
    write_reg(REG_WARP_SCALE, s);
    write_reg(REG_BAND_COUNT, bc);
    settings_run++;
  endtask

  // Offer one item, in bursts with random gaps, and hold until accepted
  task automatic send_item(bit mode, logic [15:0] mag, bit last, logic [5:0] idx,
                           logic [9:0] eb);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        bin_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    bin_if.valid <= 1'b1;
    bin_if.mode <= mode;
    bin_if.magnitude <= mag;
    bin_if.frame_last <= last;
    bin_if.edge_index <= idx;
    bin_if.edge_bin <= eb;
    @(posedge clk_i);
    while (!bin_if.ready) @(posedge clk_i);
  endtask

  task automatic send_bin(logic [15:0] mag, bit last);
    send_item(1'b0, mag, last, 6'($urandom), 10'($urandom));
  endtask

  task automatic write_edge(logic [5:0] idx, logic [9:0] eb);
    send_item(1'b1, 16'($urandom), 1'($urandom), idx, eb);
    if (idx <= 32) edge_shadow[idx] = (eb > 512) ? 512 : eb;
  endtask

  // Drop valid, drain every expected level, then let the block go idle
  task automatic settle();
    bin_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_mag();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly rising edges up to entry top, with some empty and reversed bands
  task automatic load_edges(int unsigned maxw, int unsigned top);
    int unsigned e;
    e = $urandom_range(0, 3);
    write_edge(6'd0, 10'(e));
    for (int i = 1; i <= int'(top); i++) begin
      case ($urandom_range(0, 7))
        0: e = (e > 3) ? e - $urandom_range(1, 3) : 0;
        1: ;
        default: e = e + $urandom_range(1, maxw);
      endcase
      if (e > 512) e = 512;
      write_edge(i[5:0], 10'(e));
    end
  endtask

  task automatic send_frame(int unsigned nbins, bit counted);
    for (int j = 0; j < nbins; j++) begin
      if ($urandom_range(0, 11) == 0)
        write_edge(6'($urandom_range(33, 63)), 10'($urandom));
      send_bin(pick_mag(), j == nbins - 1);
      if (counted) random_bins++;
    end
  endtask

  initial begin
    int unsigned ph, bc, bc_eff, frame_end, nbins, nframes;
    bin_if.valid <= 1'b0;
    bin_if.mode <= 1'b0;
    bin_if.magnitude <= '0;
    bin_if.frame_last <= 1'b0;
    bin_if.edge_index <= '0;
    bin_if.edge_bin <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed: edges with an empty and a reversed band, top edge clamped
    write_reg(REG_BAND_COUNT, 8);
    write_edge(6'd0, 10'd0);
    write_edge(6'd1, 10'd1);
    write_edge(6'd2, 10'd3);
    write_edge(6'd3, 10'd3);
    write_edge(6'd4, 10'd7);
    write_edge(6'd5, 10'd5);
    write_edge(6'd6, 10'd9);
    for (int i = 7; i < 32; i++) write_edge(i[5:0], 10'(i + 3));
    write_edge(6'd32, 10'h3FF);
    write_edge(6'd40, 10'd2);
    write_edge(6'd63, 10'd7);
    send_item(1'b1, 16'hFFFF, 1'b1, 6'd33, 10'd1);
    for (int j = 0; j < 11; j++) send_bin((j < 5) ? 16'hFFFF : 16'd0, j == 10);
    // Short frame: frame end closes the open bands
    send_bin(16'hFFFF, 1'b0);
    send_bin(16'd0, 1'b0);
    send_bin(16'd1, 1'b1);
    // Band count lowered mid-frame
    for (int j = 0; j < 4; j++) send_bin(16'h8000, 1'b0);
    settle();
    write_reg(REG_BAND_COUNT, 2);
    for (int j = 0; j < 4; j++) send_bin(16'h7FFF, j == 3);
    settle();

    // Random phases over several register settings; short frames end early
    ph = 0;
    while (ph < 5) begin
      case (ph)
        0: begin
          bc = 63;
          write_all(0, 0, 0, 0, 0, 0, 0, bc);
        end
        1: begin
          bc = 0;
          write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, bc);
        end
        2: begin
          bc = 8;
          write_all(32768, 32768, 32768, 32768, 32768, $urandom, $urandom, bc);
        end
        3: begin
          bc = 32;
          write_all(16384, 31130, 32440, 29491, 16384, 2560, 1708, bc);
        end
        default: begin
          bc = $urandom_range(1, 12);
          write_all($urandom_range(0, 32768), $urandom_range(0, 32768),
                    $urandom_range(0, 32768), $urandom_range(0, 32768),
                    $urandom_range(0, 32768), $urandom, $urandom, bc);
        end
      endcase
      bc_eff = (bc < 1) ? 1 : (bc > 32) ? 32 : bc;
      if (ph != 0 && ph != 3) load_edges($urandom_range(1, 4), bc_eff);
      no_gaps = (ph % 3 == 2);
      if (ph == 2) hold_req = 1'b1;
      frame_end = edge_shadow[bc_eff];
      nframes = $urandom_range(1, 2);
      for (int f = 0; f < nframes; f++) begin
        nbins = frame_end + $urandom_range(0, 6);
        nbins = (nbins > 4) ? nbins - 3 : 1;
        if (nbins > 8) nbins = 8;
        send_frame(nbins, 1'b1);
      end
      settle();
      ph++;
    end
    no_gaps = 1'b0;

    $display("Run covered %0d items (%0d random bins) and %0d band levels",
             items_seen, random_bins, levels_seen);
    $display("over %0d register settings, with one long output hold", settings_run);
    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
